### rtl/pipr_pkg.sv
package pipr_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int VADDR_W      = $clog2(MAX_VERTICES);
  localparam int VCNT_W       = $clog2(MAX_VERTICES + 1);
  localparam int COORD_W      = 17;
  localparam int CROSS_W      = 7;
  localparam int PROD_W       = 38;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_QUERY  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FEW  = 2'd1,
    ST_DROP = 2'd2
  } status_t;

  typedef enum logic {
    CFG_RAY_END_Y = 1'b0,
    CFG_EDGE_TOL  = 1'b1
  } cfg_index_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_START,
    OP_FIRST,
    OP_LOAD,
    OP_CLOSE,
    OP_DIFF,
    OP_M1,
    OP_M2,
    OP_M3,
    OP_NORM,
    OP_MLO,
    OP_MHI,
    OP_CMP,
    OP_EMIT
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIRST,
    S_LOAD,
    S_CLOSE,
    S_DIFF,
    S_M1,
    S_M2,
    S_M3,
    S_NORM,
    S_MLO,
    S_MHI,
    S_CMP,
    S_DONE
  } state_t;

  typedef struct packed {
    op_t     op;
    status_t status;
    logic    few;
  } cmd_t;

endpackage

### rtl/pipr_ram.sv
module pipr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/pipr_ctrl.sv
module pipr_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   kind,
  output logic                         out_valid,
  input  logic                         out_ready,
  output pipr_pkg::cmd_t               cmd,
  output logic                         we,
  output logic [pipr_pkg::VADDR_W-1:0] waddr,
  output logic [pipr_pkg::VADDR_W-1:0] raddr
);

  localparam logic [pipr_pkg::VCNT_W-1:0] VCNT_MAX =
    pipr_pkg::VCNT_W'(pipr_pkg::MAX_VERTICES);
  localparam logic [pipr_pkg::VCNT_W-1:0] VCNT_ONE = pipr_pkg::VCNT_W'(1);
  localparam logic [pipr_pkg::VCNT_W-1:0] VCNT_TWO = pipr_pkg::VCNT_W'(2);

  pipr_pkg::state_t            state, state_next;
  logic [pipr_pkg::VCNT_W-1:0] vcount, vcount_next;
  logic [pipr_pkg::VCNT_W-1:0] idx, idx_next;
  logic                        dropped, dropped_next;
  logic                        few, few_next;
  logic                        closing, closing_next;
  logic                        emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pipr_pkg::S_IDLE;
      vcount    <= '0;
      idx       <= '0;
      dropped   <= 1'b0;
      few       <= 1'b0;
      closing   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      vcount  <= vcount_next;
      idx     <= idx_next;
      dropped <= dropped_next;
      few     <= few_next;
      closing <= closing_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next   = state;
    vcount_next  = vcount;
    idx_next     = idx;
    dropped_next = dropped;
    few_next     = few;
    closing_next = closing;
    in_ready     = 1'b0;
    we           = 1'b0;
    waddr        = vcount[pipr_pkg::VADDR_W-1:0];
    raddr        = idx[pipr_pkg::VADDR_W-1:0];
    emit         = 1'b0;
    cmd.op       = pipr_pkg::OP_NONE;
    cmd.few      = few;
    if (few) begin
      cmd.status = pipr_pkg::ST_FEW;
    end else if (dropped) begin
      cmd.status = pipr_pkg::ST_DROP;
    end else begin
      cmd.status = pipr_pkg::ST_OK;
    end

    unique case (state)
      pipr_pkg::S_IDLE: begin
        in_ready = 1'b1;
        raddr    = '0;
        if (in_valid) begin
          unique case (kind)
            pipr_pkg::KIND_CLEAR: begin
              vcount_next  = '0;
              dropped_next = 1'b0;
            end
            pipr_pkg::KIND_APPEND: begin
              if (vcount < VCNT_MAX) begin
                we          = 1'b1;
                vcount_next = vcount + 1'b1;
              end else begin
                dropped_next = 1'b1;
              end
            end
            pipr_pkg::KIND_QUERY: begin
              if (vcount < VCNT_TWO) begin
                few_next   = 1'b1;
                state_next = pipr_pkg::S_DONE;
              end else begin
                few_next     = 1'b0;
                closing_next = 1'b0;
                idx_next     = VCNT_ONE;
                cmd.op       = pipr_pkg::OP_START;
                state_next   = pipr_pkg::S_FIRST;
              end
            end
            default: ;
          endcase
        end
      end
      pipr_pkg::S_FIRST: begin
        cmd.op     = pipr_pkg::OP_FIRST;
        state_next = pipr_pkg::S_LOAD;
      end
      pipr_pkg::S_LOAD: begin
        cmd.op     = pipr_pkg::OP_LOAD;
        idx_next   = idx + 1'b1;
        state_next = pipr_pkg::S_DIFF;
      end
      pipr_pkg::S_CLOSE: begin
        cmd.op       = pipr_pkg::OP_CLOSE;
        closing_next = 1'b1;
        state_next   = pipr_pkg::S_DIFF;
      end
      pipr_pkg::S_DIFF: begin
        cmd.op     = pipr_pkg::OP_DIFF;
        state_next = pipr_pkg::S_M1;
      end
      pipr_pkg::S_M1: begin
        cmd.op     = pipr_pkg::OP_M1;
        state_next = pipr_pkg::S_M2;
      end
      pipr_pkg::S_M2: begin
        cmd.op     = pipr_pkg::OP_M2;
        state_next = pipr_pkg::S_M3;
      end
      pipr_pkg::S_M3: begin
        cmd.op     = pipr_pkg::OP_M3;
        state_next = pipr_pkg::S_NORM;
      end
      pipr_pkg::S_NORM: begin
        cmd.op     = pipr_pkg::OP_NORM;
        state_next = pipr_pkg::S_MLO;
      end
      pipr_pkg::S_MLO: begin
        cmd.op     = pipr_pkg::OP_MLO;
        state_next = pipr_pkg::S_MHI;
      end
      pipr_pkg::S_MHI: begin
        cmd.op     = pipr_pkg::OP_MHI;
        state_next = pipr_pkg::S_CMP;
      end
      pipr_pkg::S_CMP: begin
        cmd.op = pipr_pkg::OP_CMP;
        if (closing) begin
          state_next = pipr_pkg::S_DONE;
        end else if (idx == vcount) begin
          state_next = pipr_pkg::S_CLOSE;
        end else begin
          // read address goes out now, data lands for the load step
          state_next = pipr_pkg::S_LOAD;
        end
      end
      pipr_pkg::S_DONE: begin
        if (!out_valid || out_ready) begin
          emit       = 1'b1;
          cmd.op     = pipr_pkg::OP_EMIT;
          state_next = pipr_pkg::S_IDLE;
        end
      end
      default: state_next = pipr_pkg::S_IDLE;
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    vcount <= VCNT_MAX)
    else $error("vertex count above capacity");

  a_walk_needs_edge: assert property (@(posedge clk) disable iff (rst)
    (state != pipr_pkg::S_IDLE && state != pipr_pkg::S_DONE) |-> vcount >= VCNT_TWO)
    else $error("edge walk with fewer than two vertices");

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    (state != pipr_pkg::S_IDLE && state != pipr_pkg::S_DONE) |-> idx <= vcount)
    else $error("walk index past vertex count");

  a_drop_when_full: assert property (@(posedge clk) disable iff (rst)
    $rose(dropped) |-> $past(vcount) == VCNT_MAX)
    else $error("drop flagged with room left");

endmodule

### rtl/pipr_dp.sv
module pipr_dp (
  input  logic                                clk,
  input  pipr_pkg::cmd_t                      cmd,
  input  logic signed [pipr_pkg::COORD_W-1:0] x,
  input  logic signed [pipr_pkg::COORD_W-1:0] y,
  input  logic [15:0]                         ray_end_y,
  input  logic [7:0]                          edge_tolerance,
  input  logic [2*pipr_pkg::COORD_W-1:0]      rdata,
  output logic                                inside_res,
  output logic [pipr_pkg::CROSS_W-1:0]        crossings,
  output logic [1:0]                          status
);

  localparam int CW = pipr_pkg::COORD_W;
  localparam int PW = pipr_pkg::PROD_W;

  logic signed [CW-1:0]   px, py, fx, fy, ax, ay, bx, by;
  logic signed [CW-1:0]   rx, ry;
  logic signed [CW:0]     a2, den;
  logic signed [CW+1:0]   lo, hi, dena;
  logic                   skip;
  logic signed [PW-1:0]   acc, num, plo, phi, prod;
  logic signed [CW+1:0]   opa, opb;
  logic [pipr_pkg::CROSS_W-1:0] xcount;

  // edge setup terms
  logic signed [CW:0]   py_e, rey_e, ay_e, by_e, ax_e, bx_e, px_e;
  logic signed [CW:0]   mn1, mx1, mn2, mx2, mnx, mxx;
  logic signed [CW+1:0] tol_e, lo1, hi1, lo2, hi2, xlo, xhi, px_w;

  assign rx = $signed(rdata[2*CW-1:CW]);
  assign ry = $signed(rdata[CW-1:0]);

  always_comb begin
    py_e  = {py[CW-1], py};
    rey_e = $signed({2'b00, ray_end_y});
    ay_e  = {ay[CW-1], ay};
    by_e  = {by[CW-1], by};
    ax_e  = {ax[CW-1], ax};
    bx_e  = {bx[CW-1], bx};
    px_e  = {px[CW-1], px};
    tol_e = $signed({{(CW+2-8){1'b0}}, edge_tolerance});
    mn1   = (py_e < rey_e) ? py_e : rey_e;
    mx1   = (py_e > rey_e) ? py_e : rey_e;
    mn2   = (ay_e < by_e) ? ay_e : by_e;
    mx2   = (ay_e > by_e) ? ay_e : by_e;
    mnx   = (ax_e < bx_e) ? ax_e : bx_e;
    mxx   = (ax_e > bx_e) ? ax_e : bx_e;
    lo1   = {mn1[CW], mn1} - tol_e;
    hi1   = {mx1[CW], mx1} + tol_e;
    lo2   = {mn2[CW], mn2} - tol_e;
    hi2   = {mx2[CW], mx2} + tol_e;
    xlo   = {mnx[CW], mnx} - tol_e;
    xhi   = {mxx[CW], mxx} + tol_e;
    px_w  = {px_e[CW], px_e};
  end

  // shared multiplier, operands picked by step
  always_comb begin
    unique case (cmd.op)
      pipr_pkg::OP_M1: begin
        opa = {{2{ax[CW-1]}}, ax};
        opb = {{2{by[CW-1]}}, by};
      end
      pipr_pkg::OP_M2: begin
        opa = {{2{bx[CW-1]}}, bx};
        opb = {{2{ay[CW-1]}}, ay};
      end
      pipr_pkg::OP_M3: begin
        opa = {{2{px[CW-1]}}, px};
        opb = {a2[CW], a2};
      end
      pipr_pkg::OP_MLO: begin
        opa = lo;
        opb = dena;
      end
      pipr_pkg::OP_MHI: begin
        opa = hi;
        opb = dena;
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
    prod = opa * opb;
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      pipr_pkg::OP_START: begin
        px     <= x;
        py     <= y;
        xcount <= '0;
      end
      pipr_pkg::OP_FIRST: begin
        fx <= rx;
        fy <= ry;
        bx <= rx;
        by <= ry;
      end
      pipr_pkg::OP_LOAD: begin
        ax <= bx;
        ay <= by;
        bx <= rx;
        by <= ry;
      end
      pipr_pkg::OP_CLOSE: begin
        ax <= bx;
        ay <= by;
        bx <= fx;
        by <= fy;
      end
      pipr_pkg::OP_DIFF: begin
        a2   <= by_e - ay_e;
        den  <= ax_e - bx_e;
        lo   <= (lo1 > lo2) ? lo1 : lo2;
        hi   <= (hi1 < hi2) ? hi1 : hi2;
        skip <= (rey_e == py_e) || (ax == bx) || (px_w < xlo) || (px_w > xhi);
      end
      pipr_pkg::OP_M1: acc <= prod;
      pipr_pkg::OP_M2: acc <= acc - prod;
      pipr_pkg::OP_M3: acc <= acc - prod;
      pipr_pkg::OP_NORM: begin
        if (den[CW]) begin
          num  <= -acc;
          dena <= -{den[CW], den};
        end else begin
          num  <= acc;
          dena <= {den[CW], den};
        end
      end
      pipr_pkg::OP_MLO: plo <= prod;
      pipr_pkg::OP_MHI: phi <= prod;
      pipr_pkg::OP_CMP: begin
        if (!skip && plo <= num && num <= phi) begin
          xcount <= xcount + 1'b1;
        end
      end
      pipr_pkg::OP_EMIT: begin
        inside_res <= cmd.few ? 1'b0 : xcount[0];
        crossings  <= cmd.few ? '0 : xcount;
        status     <= cmd.status;
      end
      default: ;
    endcase
  end

endmodule

### rtl/point_in_polygon_ray_cast.sv
// Point-in-polygon test by vertical ray casting. Vertices are appended one per
// transfer (kind 1) into a 64-entry outline RAM; kind 0 clears the outline and
// the drop flag, kind 2 queries a point. A query walks every edge including the
// closing one through a single shared 19x19 multiplier; each edge runs the
// load (or close), difference, multiply, normalise, bound-multiply and compare
// steps in turn. Fewer than two vertices give status 1 at once. Results sit in
// an output register, so the next transfer is taken while a result waits.
// Configuration: index 0 ray_end_y, index 1 edge_tolerance. The user must see
// that these are written only while idle; the block does not enforce it.
module point_in_polygon_ray_cast (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          kind,
  input  logic signed [pipr_pkg::COORD_W-1:0] x,
  input  logic signed [pipr_pkg::COORD_W-1:0] y,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                inside_res,
  output logic [pipr_pkg::CROSS_W-1:0]        crossings,
  output logic [1:0]                          status,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_index,
  input  logic [15:0]                         cfg_data
);

  logic [15:0] ray_end_y;
  logic [7:0]  edge_tolerance;

  pipr_pkg::cmd_t                       cmd;
  logic                                 we;
  logic [pipr_pkg::VADDR_W-1:0]         waddr, raddr;
  logic [2*pipr_pkg::COORD_W-1:0]       rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ray_end_y      <= '0;
      edge_tolerance <= 8'd2;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pipr_pkg::CFG_RAY_END_Y: ray_end_y      <= cfg_data;
        pipr_pkg::CFG_EDGE_TOL:  edge_tolerance <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  pipr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .we        (we),
    .waddr     (waddr),
    .raddr     (raddr)
  );

  pipr_ram #(
    .WIDTH (2 * pipr_pkg::COORD_W),
    .DEPTH (pipr_pkg::MAX_VERTICES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata ({x, y}),
    .raddr (raddr),
    .rdata (rdata)
  );

  pipr_dp u_dp (
    .clk            (clk),
    .cmd            (cmd),
    .x              (x),
    .y              (y),
    .ray_end_y      (ray_end_y),
    .edge_tolerance (edge_tolerance),
    .rdata          (rdata),
    .inside_res     (inside_res),
    .crossings      (crossings),
    .status         (status)
  );

endmodule
